/* rtl/core/epr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package epr_pkg;

  localparam int PhaseBits     = 32;
  localparam int SineIndexBits = 10;
  localparam int SineLen       = 1 << SineIndexBits;
  localparam int TopBits       = SineIndexBits + 2;

  localparam logic [16:0] OneQ16     = 17'd65536;
  localparam logic [16:0] WeightRst  = 17'd655;
  localparam logic [31:0] DpOneQ30   = 32'sh4000_0000;

  localparam logic [1:0] CfgPhaseStep = 2'd0;
  localparam logic [1:0] CfgAlpha     = 2'd1;
  localparam logic [1:0] CfgBeta      = 2'd2;

  localparam int QueueDepth = 2;

  // Work item handed from the front end to the datapath.
  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [16:0] zc;
    logic signed [16:0] zs;
  } work_t;

  // Quarter-wave sine entry, built from a truncated Taylor series so that
  // every entry is bit exact. Only ever called with constant arguments, so
  // the table is fixed when the design is elaborated.
  function automatic logic [15:0] make_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    x    = (64'd1686629713 * 64'(k)) >> SineIndexBits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/epr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module epr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [15:0]                   in_sample_in,
  output logic                               in_stall,
  input  wire logic [epr_pkg::PhaseBits-1:0] phase_step,
  output logic                               q_valid,
  output epr_pkg::work_t                     q_item,
  input  wire logic                          q_pop
);

  localparam int D = epr_pkg::QueueDepth;

  logic [epr_pkg::PhaseBits-1:0]     phase_acc_r, phase_acc_nxt;
  epr_pkg::work_t                    mem_r [D];
  logic                              wp_r, rp_r;
  logic [1:0]                        cnt_r;
  logic                              push;
  logic [epr_pkg::TopBits-1:0]       top;
  epr_pkg::work_t                    w;
  logic [15:0]                       sine_rom [epr_pkg::SineLen];
  logic [1:0]                        quad_sin, quad_cos;
  logic [epr_pkg::SineIndexBits-1:0] idx;
  logic [epr_pkg::SineIndexBits:0]   j_sin, j_cos;
  logic [15:0]                       mag_sin, mag_cos;

  // Fixed quarter-wave table; every entry is a constant.
  for (genvar k = 0; k < epr_pkg::SineLen; k++) begin : g_rom
    assign sine_rom[k] = epr_pkg::make_sine(k);
  end

  assign in_stall = (cnt_r == 2'(D));
  assign push     = in_valid && !in_stall;
  assign top      = phase_acc_r[epr_pkg::PhaseBits-1 -: epr_pkg::TopBits];

  // Odd quadrants read the table mirrored; the mirror of index zero is full
  // scale. The upper quadrant bit flips the sign.
  always_comb begin
    quad_sin = top[epr_pkg::TopBits-1 -: 2];
    quad_cos = quad_sin + 2'd1;
    idx      = top[epr_pkg::SineIndexBits-1:0];
    j_sin    = quad_sin[0] ? (epr_pkg::SineIndexBits+1)'(epr_pkg::SineLen) - {1'b0, idx}
                           : {1'b0, idx};
    j_cos    = quad_cos[0] ? (epr_pkg::SineIndexBits+1)'(epr_pkg::SineLen) - {1'b0, idx}
                           : {1'b0, idx};
    mag_sin  = j_sin[epr_pkg::SineIndexBits] ? 16'd32767
                                             : sine_rom[j_sin[epr_pkg::SineIndexBits-1:0]];
    mag_cos  = j_cos[epr_pkg::SineIndexBits] ? 16'd32767
                                             : sine_rom[j_cos[epr_pkg::SineIndexBits-1:0]];
    w.sample = $signed(in_sample_in);
    w.zc     = quad_cos[1] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
    w.zs     = quad_sin[1] ? $signed({1'b0, mag_sin}) : -$signed({1'b0, mag_sin});
    phase_acc_nxt = push ? phase_acc_r + phase_step : phase_acc_r;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= w;
    if (!rst_n) begin
      phase_acc_r <= '0;
      wp_r        <= 1'b0;
      rp_r        <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/epr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module epr_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  epr_pkg::work_t          q_item,
  output logic                    q_pop,
  input  wire logic [16:0]        alpha,
  input  wire logic [16:0]        beta,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_smooth_real,
  output logic signed [23:0]      out_smooth_imag,
  output logic signed [31:0]      out_dphase_real,
  output logic signed [31:0]      out_dphase_imag,
  output logic                    busy
);

  // One step per cycle. The main multiplier (at most 25x33 bits) feeds the
  // accumulate chain; a side multiplier (at most 18x32 bits) forms the
  // sample-phasor products and the delta-phase decay terms ahead of use.
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_RR1 = 16'h0002, S_RR2 = 16'h0004, S_RI1 = 16'h0008,
    S_RI2  = 16'h0010, S_SR1 = 16'h0020, S_SR2 = 16'h0040, S_SI1 = 16'h0080,
    S_SI2  = 16'h0100, S_PR1 = 16'h0200, S_PR2 = 16'h0400, S_PI1 = 16'h0800,
    S_PI2  = 16'h1000, S_DR2 = 16'h2000, S_DI2 = 16'h4000, S_OUT = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  epr_pkg::work_t    item_r;
  logic signed [63:0] acc_r, acc_nxt, acc_base;
  logic signed [24:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [57:0] prod;
  logic signed [17:0] side_a;
  logic signed [31:0] side_b;
  logic signed [49:0] side_prod;
  logic signed [32:0] sz_r;
  logic signed [49:0] dpo_re_r, dpo_im_r;
  logic signed [23:0] res_re_r, res_im_r, sm_re_r, sm_im_r, pv_re_r, pv_im_r;
  logic signed [31:0] dp_re_r, dp_im_r, p_re_r, p_im_r;
  logic signed [17:0] oma, omb, a_s, b_s;

  assign a_s = $signed({1'b0, alpha});
  assign b_s = $signed({1'b0, beta});
  assign oma = $signed(18'd65536) - a_s;
  assign omb = $signed(18'd65536) - b_s;

  function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                 input int sh);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v,
                                             input int bits);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  // Operand selection. The first step of each sum starts from zero, the
  // delta-phase steps start from the decay term formed earlier.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_base = acc_r;
    side_a   = '0;
    side_b   = '0;
    unique case (state_r)
      S_RR1: begin
        mul_a    = 25'(oma);
        mul_b    = 33'(res_re_r) <<< 7;
        acc_base = '0;
        side_a   = 18'(item_r.sample);
        side_b   = 32'(item_r.zc);
      end
      S_RR2: begin mul_a = 25'(a_s); mul_b = sz_r; end
      S_RI1: begin
        mul_a    = 25'(oma);
        mul_b    = 33'(res_im_r) <<< 7;
        acc_base = '0;
        side_a   = 18'(item_r.sample);
        side_b   = 32'(item_r.zs);
      end
      S_RI2: begin mul_a = 25'(a_s); mul_b = sz_r; end
      S_SR1: begin
        mul_a    = 25'(omb);
        mul_b    = 33'(sm_re_r);
        acc_base = '0;
        side_a   = oma;
        side_b   = dp_re_r;
      end
      S_SR2: begin mul_a = 25'(b_s); mul_b = 33'(res_re_r); end
      S_SI1: begin
        mul_a    = 25'(omb);
        mul_b    = 33'(sm_im_r);
        acc_base = '0;
        side_a   = oma;
        side_b   = dp_im_r;
      end
      S_SI2: begin mul_a = 25'(b_s); mul_b = 33'(res_im_r); end
      S_PR1: begin mul_a = 25'(sm_re_r); mul_b = 33'(pv_re_r); acc_base = '0; end
      S_PR2: begin mul_a = 25'(sm_im_r); mul_b = 33'(pv_im_r); end
      S_PI1: begin mul_a = 25'(sm_im_r); mul_b = 33'(pv_re_r); acc_base = '0; end
      S_PI2: begin mul_a = -25'(sm_re_r); mul_b = 33'(pv_im_r); end
      S_DR2: begin mul_a = 25'(a_s); mul_b = 33'(p_re_r); acc_base = 64'(dpo_re_r); end
      S_DI2: begin mul_a = 25'(a_s); mul_b = 33'(p_im_r); acc_base = 64'(dpo_im_r); end
      default: ;
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign side_prod = side_a * side_b;
  assign acc_nxt   = acc_base + 64'(prod);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      S_IDLE: if (q_valid) begin q_pop = 1'b1; state_nxt = S_RR1; end
      S_RR1: state_nxt = S_RR2;
      S_RR2: state_nxt = S_RI1;
      S_RI1: state_nxt = S_RI2;
      S_RI2: state_nxt = S_SR1;
      S_SR1: state_nxt = S_SR2;
      S_SR2: state_nxt = S_SI1;
      S_SI1: state_nxt = S_SI2;
      S_SI2: state_nxt = S_PR1;
      S_PR1: state_nxt = S_PR2;
      S_PR2: state_nxt = S_PI1;
      S_PI1: state_nxt = S_PI2;
      S_PI2: state_nxt = S_DR2;
      S_DR2: state_nxt = S_DI2;
      S_DI2: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = (state_r == S_OUT);
  assign busy            = (state_r != S_IDLE);
  assign out_smooth_real = sm_re_r;
  assign out_smooth_imag = sm_im_r;
  assign out_dphase_real = dp_re_r;
  assign out_dphase_imag = dp_im_r;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (q_pop) item_r <= q_item;
    if (state_r == S_RR1 || state_r == S_RI1) sz_r <= 33'(side_prod);
    if (state_r == S_SR1) dpo_re_r <= side_prod;
    if (state_r == S_SI1) dpo_im_r <= side_prod;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      res_re_r <= '0;
      res_im_r <= '0;
      sm_re_r  <= '0;
      sm_im_r  <= '0;
      pv_re_r  <= '0;
      pv_im_r  <= '0;
      p_re_r   <= '0;
      p_im_r   <= '0;
      dp_re_r  <= epr_pkg::DpOneQ30;
      dp_im_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_RR2: res_re_r <= 24'(sat(rshift(acc_nxt, 23), 24));
        S_RI2: res_im_r <= 24'(sat(rshift(acc_nxt, 23), 24));
        S_SR2: begin
          pv_re_r <= sm_re_r;
          sm_re_r <= 24'(sat(rshift(acc_nxt, 16), 24));
        end
        S_SI2: begin
          pv_im_r <= sm_im_r;
          sm_im_r <= 24'(sat(rshift(acc_nxt, 16), 24));
        end
        S_PR2: p_re_r <= 32'(rshift(acc_nxt, 16));
        S_PI2: p_im_r <= 32'(rshift(acc_nxt, 16));
        S_DR2: dp_re_r <= sat(rshift(acc_nxt, 16), 32);
        S_DI2: dp_im_r <= sat(rshift(acc_nxt, 16), 32);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ewma_phasor_resonator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_sample_in (Q1.15)
// out_      output     out_valid/out_stall  smooth re/im (Q1.23), dphase re/im (Q2.30)
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// Each request passes through the datapath sequencer: it is taken from the
// queue, runs fourteen multiply-accumulate steps, and its result is offered
// and held for as long as it is stalled. A two-entry queue between the
// phase/sine front end and the sequencer lets input be taken while a result
// waits; in_stall rises only when it is full.
// Reset is synchronous and active low; it clears all filter state, sets the
// delta-phase real part to one, and restores the weights to 655.
module ewma_phasor_resonator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_sample_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_smooth_real,
  output logic signed [23:0]      out_smooth_imag,
  output logic signed [31:0]      out_dphase_real,
  output logic signed [31:0]      out_dphase_imag,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [epr_pkg::PhaseBits-1:0] phase_step_r;
  logic [16:0]                   alpha_r, beta_r;
  logic                          q_valid, q_pop, busy;
  epr_pkg::work_t                q_item;

  // Weights above one are ignored; unknown indexes do nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      alpha_r      <= epr_pkg::WeightRst;
      beta_r       <= epr_pkg::WeightRst;
    end else if (cfg_we) begin
      if (cfg_index == epr_pkg::CfgPhaseStep)
        phase_step_r <= cfg_data[epr_pkg::PhaseBits-1:0];
      else if (cfg_index == epr_pkg::CfgAlpha && cfg_data[16:0] <= epr_pkg::OneQ16)
        alpha_r <= cfg_data[16:0];
      else if (cfg_index == epr_pkg::CfgBeta && cfg_data[16:0] <= epr_pkg::OneQ16)
        beta_r <= cfg_data[16:0];
    end
  end

  epr_front u_front (
    .clk, .rst_n, .in_valid, .in_sample_in, .in_stall,
    .phase_step(phase_step_r), .q_valid, .q_item, .q_pop
  );

  epr_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .alpha(alpha_r), .beta(beta_r),
    .out_valid, .out_stall, .out_smooth_real, .out_smooth_imag,
    .out_dphase_real, .out_dphase_imag, .busy
  );

  // A pop only happens when the queue holds a request.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");
  // A result stays offered under a stall and its delta-phase real part does not change.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_stall |=> out_valid && $stable(out_dphase_real))
    else $error("result changed under stall");
  // The sequencer is busy whenever a result is offered.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result without active sequencer");

endmodule
`default_nettype wire
